// ===== design/mhpq_pkg.sv =====
// package for the min-heap priority queue
// holds operation and status codes and the fixed port widths; no dependencies
package mhpq_pkg;

   localparam int KEY_OUT_W = 32;
   localparam int DELTA_W   = 32;
   localparam int POS_W     = 5;
   localparam int COUNT_W   = 5;

   typedef enum logic [1:0] {
      OP_INSERT  = 2'd0,
      OP_EXTRACT = 2'd1,
      OP_PEEK    = 2'd2,
      OP_ADJUST  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_FULL    = 2'd2,
      ST_BAD_POS = 2'd3
   } status_type;

endpackage

// ===== design/min_heap_priority_queue.sv =====
// min-heap priority queue: key memory, sift sequencer and one shared compare unit
// depends on mhpq_pkg
//
// One operation is taken when start is high and busy is low; exactly one result
// follows, shown for a single cycle with rsp_valid, and the receiver cannot stall
// it. Failed operations answer in the cycle after the transfer. Peek answers from
// S_PEEK_LD with the root. Insert climbs from the new last slot, one level per
// S_UP_RD and S_UP_CMP pass; extract and adjust load in S_EXT_LD or S_ADJ_LD, then
// walk down (or up for a decreased key) one level per read and compare pass.
// Each heap level costs a read state for the key memory's registered read and a
// compare-and-write state. No clearing pass runs after reset; keys read from slots
// at or above the count are never used.
module min_heap_priority_queue
   import mhpq_pkg::*;
#(
   parameter int CAPACITY  = 16,
   parameter int KEY_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  op_type                      req_operation,
   input  logic signed [KEY_OUT_W-1:0] req_new_key,
   input  logic [POS_W-1:0]            req_position,
   input  logic signed [DELTA_W-1:0]   req_delta,
   output logic                        rsp_valid,
   output logic signed [KEY_OUT_W-1:0] rsp_min_value,
   output status_type                  rsp_status,
   output logic [COUNT_W-1:0]          rsp_count
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int LW = CW + 1;
   localparam int PW = (CW > POS_W) ? CW : POS_W;
   localparam int SW = ((KEY_WIDTH > DELTA_W) ? KEY_WIDTH : DELTA_W) + 1;
   localparam logic signed [SW-1:0] KEY_MAX_EXT =
      $signed({1'b0, {(SW-1){1'b1}}}) >>> (SW - KEY_WIDTH);
   localparam logic signed [SW-1:0] KEY_MIN_EXT = ~KEY_MAX_EXT;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PEEK_LD,
      S_EXT_LD,
      S_ADJ_LD,
      S_UP_RD,
      S_UP_CMP,
      S_DN_RD,
      S_DN_CMP
   } state_type;

   state_type                    state_ff;
   logic [CW-1:0]                count_ff;
   logic [IW-1:0]                hole_ff;
   logic signed [KEY_WIDTH-1:0]  cur_ff;
   logic signed [KEY_WIDTH-1:0]  min_ff;
   logic signed [DELTA_W-1:0]    delta_ff;
   logic                         rsp_valid_ff;
   logic signed [KEY_OUT_W-1:0]  rsp_min_value_ff;
   status_type                   rsp_status_ff;
   logic [COUNT_W-1:0]           rsp_count_ff;

   // key memory, two registered read ports, one write port
   logic signed [KEY_WIDTH-1:0]  mem [CAPACITY];
   logic signed [KEY_WIDTH-1:0]  rd_a_ff;
   logic signed [KEY_WIDTH-1:0]  rd_b_ff;
   logic [IW-1:0]                ra_a;
   logic [IW-1:0]                ra_b;
   logic                         mem_we;
   logic [IW-1:0]                mem_wa;
   logic signed [KEY_WIDTH-1:0]  mem_wd;

   logic [IW-1:0]                parent_idx;
   logic [LW-1:0]                l_idx;
   logic [LW-1:0]                r_idx;
   logic                         l_ok;
   logic                         r_ok;
   logic [PW-1:0]                pos_ext;
   logic                         pos_bad;
   logic [IW-1:0]                adj_idx;
   logic signed [KEY_WIDTH-1:0]  ins_key;
   logic signed [SW-1:0]         adj_sum;
   logic signed [KEY_WIDTH-1:0]  adj_key;
   logic                         up_move;
   logic                         l_less;
   logic signed [KEY_WIDTH-1:0]  best_val;
   logic                         pick_r;
   logic                         dn_move;
   logic [IW-1:0]                child_idx;
   logic signed [KEY_WIDTH-1:0]  child_val;

   function automatic logic signed [KEY_WIDTH-1:0] clamp_key(input logic signed [SW-1:0] v);
      logic signed [KEY_WIDTH-1:0] r;
      if (v > KEY_MAX_EXT) begin
         r = KEY_WIDTH'(KEY_MAX_EXT);
      end else if (v < KEY_MIN_EXT) begin
         r = KEY_WIDTH'(KEY_MIN_EXT);
      end else begin
         r = KEY_WIDTH'(v);
      end
      return r;
   endfunction

   // index arithmetic
   assign parent_idx = (hole_ff - IW'(1)) >> 1;
   assign l_idx      = LW'({hole_ff, 1'b1});
   assign r_idx      = l_idx + LW'(1);
   assign l_ok       = l_idx < LW'(count_ff);
   assign r_ok       = r_idx < LW'(count_ff);
   assign pos_ext    = PW'(req_position);
   assign pos_bad    = (pos_ext == '0) || (pos_ext > PW'(count_ff));
   assign adj_idx    = IW'(pos_ext - PW'(1));

   // key arithmetic: clamp on insert, saturating add on adjust
   assign ins_key = clamp_key(SW'(req_new_key));
   assign adj_sum = SW'(rd_a_ff) + SW'(delta_ff);
   assign adj_key = clamp_key(adj_sum);

   // shared compare unit
   assign up_move   = cur_ff < rd_a_ff;
   assign l_less    = rd_a_ff < cur_ff;
   assign best_val  = l_less ? rd_a_ff : cur_ff;
   assign pick_r    = r_ok && (rd_b_ff < best_val);
   assign dn_move   = pick_r || l_less;
   assign child_idx = pick_r ? IW'(r_idx) : IW'(l_idx);
   assign child_val = pick_r ? rd_b_ff : rd_a_ff;

   // memory addressing and write-back
   always_comb begin
      ra_a   = '0;
      ra_b   = '0;
      mem_we = 1'b0;
      mem_wa = hole_ff;
      mem_wd = cur_ff;
      unique case (state_ff)
         S_IDLE: begin
            ra_a = (req_operation == OP_ADJUST) ? adj_idx : '0;
            ra_b = IW'(count_ff - CW'(1));
         end
         S_UP_RD: begin
            ra_a   = parent_idx;
            mem_we = (hole_ff == '0);
         end
         S_UP_CMP: begin
            mem_we = 1'b1;
            mem_wd = up_move ? rd_a_ff : cur_ff;
         end
         S_DN_RD: begin
            ra_a   = IW'(l_idx);
            ra_b   = r_ok ? IW'(r_idx) : IW'(l_idx);
            mem_we = !l_ok;
         end
         S_DN_CMP: begin
            mem_we = 1'b1;
            mem_wd = dn_move ? child_val : cur_ff;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_a_ff <= mem[ra_a];
      rd_b_ff <= mem[ra_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  min_ff        <= '0;
                  delta_ff      <= req_delta;
                  rsp_status_ff <= ST_OK;
                  unique case (req_operation)
                     OP_INSERT: begin
                        if (count_ff == CW'(CAPACITY)) begin
                           rsp_valid_ff     <= 1'b1;
                           rsp_status_ff    <= ST_FULL;
                           rsp_min_value_ff <= '0;
                           rsp_count_ff     <= COUNT_W'(count_ff);
                        end else begin
                           cur_ff   <= ins_key;
                           hole_ff  <= IW'(count_ff);
                           count_ff <= count_ff + CW'(1);
                           state_ff <= S_UP_RD;
                        end
                     end
                     OP_EXTRACT: begin
                        if (count_ff == '0) begin
                           rsp_valid_ff     <= 1'b1;
                           rsp_status_ff    <= ST_EMPTY;
                           rsp_min_value_ff <= '0;
                           rsp_count_ff     <= COUNT_W'(count_ff);
                        end else begin
                           count_ff <= count_ff - CW'(1);
                           state_ff <= S_EXT_LD;
                        end
                     end
                     OP_PEEK: begin
                        if (count_ff == '0) begin
                           rsp_valid_ff     <= 1'b1;
                           rsp_status_ff    <= ST_EMPTY;
                           rsp_min_value_ff <= '0;
                           rsp_count_ff     <= COUNT_W'(count_ff);
                        end else begin
                           state_ff <= S_PEEK_LD;
                        end
                     end
                     OP_ADJUST: begin
                        if (pos_bad) begin
                           rsp_valid_ff     <= 1'b1;
                           rsp_status_ff    <= ST_BAD_POS;
                           rsp_min_value_ff <= '0;
                           rsp_count_ff     <= COUNT_W'(count_ff);
                        end else begin
                           hole_ff  <= adj_idx;
                           state_ff <= S_ADJ_LD;
                        end
                     end
                     default: begin
                        state_ff <= S_IDLE;
                     end
                  endcase
               end
            end
            S_PEEK_LD: begin
               rsp_valid_ff     <= 1'b1;
               rsp_min_value_ff <= KEY_OUT_W'(SW'(rd_a_ff));
               rsp_count_ff     <= COUNT_W'(count_ff);
               state_ff         <= S_IDLE;
            end
            S_EXT_LD: begin
               // root leaves, last entry starts its walk down from the root
               min_ff   <= rd_a_ff;
               cur_ff   <= rd_b_ff;
               hole_ff  <= '0;
               state_ff <= S_DN_RD;
            end
            S_ADJ_LD: begin
               cur_ff   <= adj_key;
               state_ff <= (adj_key < rd_a_ff) ? S_UP_RD : S_DN_RD;
            end
            S_UP_RD: begin
               if (hole_ff == '0) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_min_value_ff <= KEY_OUT_W'(SW'(min_ff));
                  rsp_count_ff     <= COUNT_W'(count_ff);
                  state_ff         <= S_IDLE;
               end else begin
                  state_ff <= S_UP_CMP;
               end
            end
            S_UP_CMP: begin
               if (up_move) begin
                  hole_ff  <= parent_idx;
                  state_ff <= S_UP_RD;
               end else begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_min_value_ff <= KEY_OUT_W'(SW'(min_ff));
                  rsp_count_ff     <= COUNT_W'(count_ff);
                  state_ff         <= S_IDLE;
               end
            end
            S_DN_RD: begin
               if (!l_ok) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_min_value_ff <= KEY_OUT_W'(SW'(min_ff));
                  rsp_count_ff     <= COUNT_W'(count_ff);
                  state_ff         <= S_IDLE;
               end else begin
                  state_ff <= S_DN_CMP;
               end
            end
            S_DN_CMP: begin
               if (dn_move) begin
                  hole_ff  <= child_idx;
                  state_ff <= S_DN_RD;
               end else begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_min_value_ff <= KEY_OUT_W'(SW'(min_ff));
                  rsp_count_ff     <= COUNT_W'(count_ff);
                  state_ff         <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_min_value = rsp_min_value_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_count     = rsp_count_ff;

   // count never passes the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("heap count above capacity");

   // every multi-cycle operation ends with a result
   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("operation finished without a result");

   // insert into a full heap is rejected with full status without going busy
   a_full_reject: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operation == OP_INSERT && count_ff == CW'(CAPACITY))
      |=> (rsp_valid && rsp_status == ST_FULL && !busy))
      else $error("insert into full heap not rejected");

   // the key memory is written only during an operation
   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> busy)
      else $error("key memory written while idle");

endmodule

// ===== tb/sv/heap_tb_pkg.sv =====
`timescale 1ns / 100ps
// scoreboard for the min-heap priority queue testbench: shadow heap and response checker
// depends on mhpq_pkg
package heap_tb_pkg;
   import mhpq_pkg::*;

   localparam int     HEAP_DEPTH = 16;
   localparam longint KEY_TOP    = 64'sd2147483647;
   localparam longint KEY_BOTTOM = -64'sd2147483648;

   typedef struct {
      logic signed [KEY_OUT_W-1:0] min_value;
      status_type                  status;
      logic [COUNT_W-1:0]          count;
   } heap_response_type;

   class heap_shadow;
      longint            slot_key[HEAP_DEPTH];
      int unsigned       n_keys;
      heap_response_type pending_responses[$];
      int unsigned       error_count;

      function new();
         n_keys      = 0;
         error_count = 0;
      endfunction

      function void swap_slots(int unsigned a, int unsigned b);
         longint held;
         held        = slot_key[a];
         slot_key[a] = slot_key[b];
         slot_key[b] = held;
      endfunction

      // moves only on a strictly smaller key
      function void climb(int unsigned at);
         int unsigned up;
         while (at > 0) begin
            up = (at - 1) / 2;
            if (!(slot_key[at] < slot_key[up])) break;
            swap_slots(at, up);
            at = up;
         end
      endfunction

      function void sink(int unsigned at);
         int unsigned left;
         int unsigned right;
         int unsigned least;
         forever begin
            left  = 2 * at + 1;
            right = left + 1;
            least = at;
            if (left < n_keys && slot_key[left] < slot_key[least]) least = left;
            if (right < n_keys && slot_key[right] < slot_key[least]) least = right;
            if (least == at) break;
            swap_slots(at, least);
            at = least;
         end
      endfunction

      // called for every accepted transfer on the request side
      function void apply_operation(op_type op, logic signed [KEY_OUT_W-1:0] key,
                                    logic [POS_W-1:0] pos, logic signed [DELTA_W-1:0] delta);
         heap_response_type r;
         longint            prior;
         longint            sum;
         int unsigned       idx;
         r.min_value = '0;
         r.status    = ST_OK;
         case (op)
            OP_INSERT: begin
               if (n_keys >= HEAP_DEPTH) begin
                  r.status = ST_FULL;
               end else begin
                  slot_key[n_keys] = longint'(key);
                  n_keys++;
                  climb(n_keys - 1);
               end
            end
            OP_EXTRACT: begin
               if (n_keys == 0) begin
                  r.status = ST_EMPTY;
               end else begin
                  r.min_value = slot_key[0][KEY_OUT_W-1:0];
                  n_keys--;
                  slot_key[0] = slot_key[n_keys];
                  sink(0);
               end
            end
            OP_PEEK: begin
               if (n_keys == 0) r.status = ST_EMPTY;
               else r.min_value = slot_key[0][KEY_OUT_W-1:0];
            end
            default: begin
               if (pos == 0 || pos > n_keys) begin
                  r.status = ST_BAD_POS;
               end else begin
                  idx   = pos - 1;
                  prior = slot_key[idx];
                  sum   = prior + longint'(delta);
                  if (sum > KEY_TOP) sum = KEY_TOP;
                  else if (sum < KEY_BOTTOM) sum = KEY_BOTTOM;
                  slot_key[idx] = sum;
                  if (sum < prior) climb(idx);
                  else sink(idx);
               end
            end
         endcase
         r.count = n_keys[COUNT_W-1:0];
         pending_responses.push_back(r);
      endfunction

      function void check_response(logic signed [KEY_OUT_W-1:0] min_value, status_type status,
                                   logic [COUNT_W-1:0] count);
         heap_response_type r;
         if (pending_responses.size() == 0) begin
            $display("%0t: response with none expected: min_value %0d status %0d count %0d",
                     $time, min_value, status, count);
            error_count++;
            return;
         end
         r = pending_responses.pop_front();
         if (min_value !== r.min_value) begin
            $display("%0t: min_value expected %0d got %0d", $time, r.min_value, min_value);
            error_count++;
         end
         if (status !== r.status) begin
            $display("%0t: status expected %0d got %0d", $time, r.status, status);
            error_count++;
         end
         if (count !== r.count) begin
            $display("%0t: count expected %0d got %0d", $time, r.count, count);
            error_count++;
         end
      endfunction
   endclass

endpackage

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// top-level testbench for min_heap_priority_queue: directed and random operation streams
// depends on mhpq_pkg, heap_tb_pkg and the design
module testbench;
   import mhpq_pkg::*;
   import heap_tb_pkg::*;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   op_type                      req_operation = OP_INSERT;
   logic signed [KEY_OUT_W-1:0] req_new_key = '0;
   logic [POS_W-1:0]            req_position = '0;
   logic signed [DELTA_W-1:0]   req_delta = '0;
   logic                        rsp_valid;
   logic signed [KEY_OUT_W-1:0] rsp_min_value;
   status_type                  rsp_status;
   logic [COUNT_W-1:0]          rsp_count;

   heap_shadow shadow = new();
   bit         allow_idle = 1'b1;

   min_heap_priority_queue u_top (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operation (req_operation),
      .req_new_key   (req_new_key),
      .req_position  (req_position),
      .req_delta     (req_delta),
      .rsp_valid     (rsp_valid),
      .rsp_min_value (rsp_min_value),
      .rsp_status    (rsp_status),
      .rsp_count     (rsp_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // a response may land on the same edge as the next transfer, so check it first
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) shadow.check_response(rsp_min_value, rsp_status, rsp_count);
         if (start && !busy)
            shadow.apply_operation(req_operation, req_new_key, req_position, req_delta);
      end
   end

   task automatic send_op(input op_type op, input logic signed [KEY_OUT_W-1:0] key,
                          input logic [POS_W-1:0] pos, input logic signed [DELTA_W-1:0] delta);
      req_operation <= op;
      req_new_key   <= key;
      req_position  <= pos;
      req_delta     <= delta;
      start         <= 1'b1;
      do @(posedge clock); while (busy);
      if (allow_idle && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   // extremes, tight clusters for equal keys, and full-range values
   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'sh7fffffff;
         1:       return 32'sh80000000;
         2, 3, 4: return int'($urandom_range(0, 15)) - 8;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int unsigned idx;
      int unsigned mode;
      int unsigned roll;
      int unsigned held;
      op_type      op;
      logic [4:0]  pos;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty heap cases
      send_op(OP_PEEK, 0, 0, 0);
      send_op(OP_EXTRACT, 0, 0, 0);
      send_op(OP_ADJUST, 0, 5'd1, 32'sd5);
      send_op(OP_ADJUST, 0, 5'd0, 32'sd5);
      // extremes and equal keys
      send_op(OP_INSERT, 32'sh7fffffff, 0, 0);
      send_op(OP_INSERT, 32'sh80000000, 0, 0);
      send_op(OP_INSERT, -32'sd1, 0, 0);
      send_op(OP_INSERT, -32'sd1, 0, 0);
      send_op(OP_PEEK, 0, 0, 0);
      // saturation both ways, out-of-range positions, a zero delta, then draining past empty
      send_op(OP_ADJUST, 0, 5'd1, 32'sh80000000);
      send_op(OP_ADJUST, 0, 5'd4, 32'sh7fffffff);
      send_op(OP_ADJUST, 0, 5'd2, 32'sh7fffffff);
      send_op(OP_ADJUST, 0, 5'd0, 32'sd1);
      send_op(OP_ADJUST, 0, 5'd5, 32'sd1);
      send_op(OP_ADJUST, 0, 5'd31, -32'sd1);
      send_op(OP_ADJUST, 0, 5'd3, 32'sd0);
      send_op(OP_EXTRACT, 0, 0, 0);
      send_op(OP_EXTRACT, 0, 0, 0);
      send_op(OP_EXTRACT, 0, 0, 0);
      send_op(OP_EXTRACT, 0, 0, 0);
      send_op(OP_EXTRACT, 0, 0, 0);

      // random part: phases biased toward filling, draining or a mix
      mode = 0;
      for (idx = 0; idx < 1200; idx++) begin
         if (idx % 60 == 0) mode = $urandom_range(0, 2);
         allow_idle = (idx < 1000);
         roll = $urandom_range(0, 99);
         if (mode == 0)
            op = (roll < 70) ? OP_INSERT : (roll < 80) ? OP_EXTRACT :
                 (roll < 85) ? OP_PEEK : OP_ADJUST;
         else if (mode == 1)
            op = (roll < 15) ? OP_INSERT : (roll < 75) ? OP_EXTRACT :
                 (roll < 85) ? OP_PEEK : OP_ADJUST;
         else
            op = (roll < 35) ? OP_INSERT : (roll < 65) ? OP_EXTRACT :
                 (roll < 75) ? OP_PEEK : OP_ADJUST;
         held = (shadow.n_keys == 0) ? 1 : shadow.n_keys;
         if ($urandom_range(0, 99) < 85) pos = 5'($urandom_range(1, held));
         else pos = 5'($urandom_range(0, 31));
         send_op(op, pick_value(), pos, pick_value());
      end
      start <= 1'b0;

      while (shadow.pending_responses.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (shadow.error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== files.f =====
design/mhpq_pkg.sv
design/min_heap_priority_queue.sv
tb/sv/heap_tb_pkg.sv
tb/sv/testbench.sv
